/* rtl/core/usdst_pkg.sv */
// widths, constants and calendar helpers for the us dst window check
package usdst_pkg;

  localparam int TS_W      = 34;
  localparam int WIN_W     = 35;
  localparam int HOUR_W    = 5;
  localparam int DAY_W     = 18;
  localparam int YOFF_W    = 11;
  localparam int CFG_IDX_W = 1;
  localparam int NSTG      = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_HOUR,
    REG_END_HOUR
  } cfg_reg_t;

  localparam logic [HOUR_W-1:0] START_HOUR_RST = 5'd7;
  localparam logic [HOUR_W-1:0] END_HOUR_RST   = 5'd6;

  // seconds to days: drop 7 bits (/128), then multiply by ceil(2^37/675)
  localparam int                 DAY_SHIFT = 37;
  localparam logic [27:0]        DAY_RECIP = 28'd203613265;
  // day count to rough year offset, 2^26/365.2425
  localparam int                 YEAR_SHIFT = 26;
  localparam logic [17:0]        YEAR_RECIP = 18'd183737;
  // divide by 7, ceil(2^21/7)
  localparam int                 WK_SHIFT = 21;
  localparam logic [18:0]        WK_RECIP = 19'd299594;

  localparam logic [16:0]        SECS_DAY  = 17'd86400;
  localparam logic [11:0]        SECS_HOUR = 12'd3600;
  // days from march 1 / november 1 to january 1 of the next year
  localparam logic [DAY_W-1:0]   MAR1_BACK = 18'd306;
  localparam logic [DAY_W-1:0]   NOV1_BACK = 18'd61;
  // 1970-01-01 was a thursday
  localparam logic [DAY_W-1:0]   WK_PHASE  = 18'd4;

  // days from 1970-01-01 to january 1 of year 1970+n
  function automatic logic [DAY_W-1:0] days_before_year(input logic [YOFF_W-1:0] n);
    logic [23:0] p100;
    logic [23:0] p400;
    logic [19:0] acc;
    p100 = (24'(n) + 24'd69) * 24'd5243;
    p400 = (24'(n) + 24'd369) * 24'd5243;
    acc  = 20'(n) * 20'd365 + 20'((12'(n) + 12'd1) >> 2)
           - 20'(p100[23:19]) + 20'(p400[23:21]);
    return acc[DAY_W-1:0];
  endfunction

endpackage

/* rtl/core/us_dst_window_check.sv */
// us dst window check: timestamp to year, march/november sunday boundaries, window flag
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------
//  cfg      | cfg_valid / cfg_ready      | cfg_index, cfg_data (hour registers)
//  item     | item_valid / item_ready    | epoch_seconds
//  result   | result_valid / result_ready| in_dst, window_start, window_end
//
// eight register stages, one transaction per cycle while result_ready holds;
// the stages follow the multiplier chain
// (seconds to days, days to year, weekday, days to seconds)
// each stage holds its own valid bit and advances when the next one is free,
// so bubbles close up while the result side stalls
// rst is synchronous: clears stage valid bits and loads hour reset values
// cfg_ready is always high; each write goes straight into its hour register
module us_dst_window_check (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [usdst_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [usdst_pkg::HOUR_W-1:0]       cfg_data,
  input  logic                               item_valid,
  output logic                               item_ready,
  input  logic [usdst_pkg::TS_W-1:0]         epoch_seconds,
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic                               in_dst,
  output logic [usdst_pkg::WIN_W-1:0]        window_start,
  output logic [usdst_pkg::WIN_W-1:0]        window_end
);
  import usdst_pkg::*;

  // hour registers
  logic [HOUR_W-1:0] start_hour;
  logic [HOUR_W-1:0] end_hour;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_hour <= START_HOUR_RST;
      end_hour   <= END_HOUR_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_START_HOUR: start_hour <= cfg_data;
        REG_END_HOUR:   end_hour   <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-stage valid and ready chain
  logic [NSTG:1] vld;
  logic [NSTG:1] rdy;

  always_comb begin
    rdy[NSTG] = !vld[NSTG] || result_ready;
    for (int i = NSTG - 1; i >= 1; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign item_ready = rdy[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) vld[1] <= item_valid;
      for (int i = 2; i <= NSTG; i++) begin
        if (rdy[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // timestamp rides along to the compare stage
  logic [TS_W-1:0] s1_t, s2_t, s3_t, s4_t, s5_t, s6_t, s7_t;

  // stage 1: seconds/128 times reciprocal of 675
  logic [54:0] s1_prod;
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_t    <= epoch_seconds;
      s1_prod <= 55'(epoch_seconds[TS_W-1:7]) * 55'(DAY_RECIP);
    end
  end

  // stage 2: day count, then rough year offset product
  logic [DAY_W-1:0] s1_days;
  logic [DAY_W-1:0] s2_days;
  logic [35:0]      s2_yprod;
  assign s1_days = s1_prod[54:DAY_SHIFT];

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_t     <= s1_t;
      s2_days  <= s1_days;
      s2_yprod <= 36'(s1_days) * 36'(YEAR_RECIP);
    end
  end

  // stage 3: january 1 of the estimated year and the two after it
  logic [YOFF_W-1:0] s2_yest;
  logic [DAY_W-1:0]  s3_days;
  logic [DAY_W-1:0]  s3_jan0, s3_jan1, s3_jan2;
  assign s2_yest = {1'b0, s2_yprod[35:YEAR_SHIFT]};

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_t    <= s2_t;
      s3_days <= s2_days;
      s3_jan0 <= days_before_year(s2_yest);
      s3_jan1 <= days_before_year(s2_yest + YOFF_W'(1));
      s3_jan2 <= days_before_year(s2_yest + YOFF_W'(2));
    end
  end

  // stage 4: estimate may be one off either way; pick next january 1,
  // step back to march 1 and november 1, add weekday phase
  logic [DAY_W-1:0] s3_next_jan;
  logic [DAY_W-1:0] s4_xm, s4_xn;
  always_comb begin
    if (s3_days < s3_jan0) s3_next_jan = s3_jan0;
    else if (s3_days < s3_jan1) s3_next_jan = s3_jan1;
    else s3_next_jan = s3_jan2;
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_t  <= s3_t;
      s4_xm <= s3_next_jan - MAR1_BACK + WK_PHASE;
      s4_xn <= s3_next_jan - NOV1_BACK + WK_PHASE;
    end
  end

  // stage 5: divide-by-7 products
  logic [DAY_W-1:0] s5_xm, s5_xn;
  logic [36:0]      s5_pm, s5_pn;
  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s5_t  <= s4_t;
      s5_xm <= s4_xm;
      s5_xn <= s4_xn;
      s5_pm <= 37'(s4_xm) * 37'(WK_RECIP);
      s5_pn <= 37'(s4_xn) * 37'(WK_RECIP);
    end
  end

  // stage 6: weekday, forward to sunday; march gets one more week
  logic [DAY_W-1:0] s5_wdm, s5_wdn;
  logic [2:0]       s5_offm, s5_offn;
  logic [DAY_W-1:0] s6_sday, s6_eday;
  assign s5_wdm = s5_xm - DAY_W'(s5_pm[36:WK_SHIFT]) * DAY_W'(7);
  assign s5_wdn = s5_xn - DAY_W'(s5_pn[36:WK_SHIFT]) * DAY_W'(7);
  assign s5_offm = (s5_wdm[2:0] == 3'd0) ? 3'd0 : 3'd7 - s5_wdm[2:0];
  assign s5_offn = (s5_wdn[2:0] == 3'd0) ? 3'd0 : 3'd7 - s5_wdn[2:0];

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s6_t    <= s5_t;
      s6_sday <= s5_xm - WK_PHASE + DAY_W'(7) + DAY_W'(s5_offm);
      s6_eday <= s5_xn - WK_PHASE + DAY_W'(s5_offn);
    end
  end

  // stage 7: boundaries in seconds
  logic [WIN_W-1:0] s7_ws, s7_we;
  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      s7_t  <= s6_t;
      s7_ws <= WIN_W'(s6_sday) * WIN_W'(SECS_DAY) + WIN_W'(start_hour) * WIN_W'(SECS_HOUR);
      s7_we <= WIN_W'(s6_eday) * WIN_W'(SECS_DAY) + WIN_W'(end_hour) * WIN_W'(SECS_HOUR);
    end
  end

  // stage 8: window compare into the output register
  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      in_dst       <= (WIN_W'(s7_t) >= s7_ws) && (WIN_W'(s7_t) < s7_we);
      window_start <= s7_ws;
      window_end   <= s7_we;
    end
  end

  assign result_valid = vld[NSTG];

  // year estimate never more than one below the true year
  assert property (@(posedge clk) disable iff (rst) vld[3] |-> s3_days < s3_jan2)
    else $error("year estimate out of range");

  // reciprocal divide by 7 leaves a true remainder
  assert property (@(posedge clk) disable iff (rst) vld[5] |-> (s5_wdm < 7 && s5_wdn < 7))
    else $error("weekday remainder out of range");

  // march boundary always precedes november boundary
  assert property (@(posedge clk) disable iff (rst) result_valid |-> window_start < window_end)
    else $error("window start not before window end");

  // a stalled stage keeps its transaction
  assert property (@(posedge clk) disable iff (rst) (vld[4] && !rdy[4]) |=> vld[4])
    else $error("stalled transaction dropped");

  // reset empties the pipeline
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// self-checking testbench for us_dst_window_check: calendar predictor, driver, monitor
module testbench;
  import usdst_pkg::*;

  // calendar arithmetic, all on 64-bit unsigned day and second counts
  localparam longint unsigned SEC_IN_DAY  = 86400;
  localparam longint unsigned SEC_IN_HOUR = 3600;
  localparam longint unsigned DAYS_400Y   = 146097;
  // days from 0000-03-01 (proleptic) to 1970-01-01
  localparam longint unsigned CIVIL_SHIFT = 719468;
  localparam longint unsigned TS_MAX      = (64'd1 << TS_W) - 1;

  // random probes land within eight days either side of a boundary
  localparam int PROBE_SPAN     = 8 * 86400;
  localparam int PIPE_DEPTH     = NSTG;
  localparam int RX_HOLD_CYCLES = 300;

  typedef struct packed {
    logic             in_dst;
    logic [WIN_W-1:0] window_start;
    logic [WIN_W-1:0] window_end;
  } dst_window_t;

  // dut ports, every input known from time zero
  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index     = REG_START_HOUR;
  logic [HOUR_W-1:0]    cfg_data      = '0;
  logic                 item_valid    = 1'b0;
  logic                 item_ready;
  logic [TS_W-1:0]      epoch_seconds = '0;
  logic                 result_valid;
  logic                 result_ready  = 1'b0;
  logic                 in_dst;
  logic [WIN_W-1:0]     window_start;
  logic [WIN_W-1:0]     window_end;

  // shadow copy of the two hour registers, updated on each accepted write
  logic [HOUR_W-1:0] open_hour  = START_HOUR_RST;
  logic [HOUR_W-1:0] close_hour = END_HOUR_RST;

  // timestamps waiting for the driver, windows waiting for the monitor
  logic [TS_W-1:0] epochs_to_send[$];
  dst_window_t     dst_windows_due[$];
  dst_window_t     due_head;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int epochs_queued   = 0;
  int epochs_accepted = 0;
  int windows_checked = 0;
  int hour_settings   = 1;
  int fail_count      = 0;

  logic rx_hold_req  = 1'b0;
  int   rx_hold_left = 0;

  us_dst_window_check u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .epoch_seconds (epoch_seconds),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .in_dst        (in_dst),
    .window_start  (window_start),
    .window_end    (window_end)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("[us_dst_window_check] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // calendar predictor
  // ---------------------------------------------------------------------------

  // gregorian year holding a day count since 1970-01-01, march-based eras
  function automatic longint unsigned civil_year(input longint unsigned days);
    longint unsigned z, era, doe, yoe, doy, mp, yr;
    z   = days + CIVIL_SHIFT;
    era = z / DAYS_400Y;
    doe = z - era * DAYS_400Y;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    yr  = yoe + era * 400;
    // january and february belong to the next calendar year
    return (mp >= 10) ? yr + 1 : yr;
  endfunction

  // day count of the first of a month, march through december
  function automatic longint unsigned day_of_first(input longint unsigned yr,
                                                   input longint unsigned month);
    longint unsigned era, yoe, doy, doe;
    era = yr / 400;
    yoe = yr - era * 400;
    doy = (153 * (month - 3) + 2) / 5;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * DAYS_400Y + doe - CIVIL_SHIFT;
  endfunction

  // 1970-01-01 was a thursday, so weekday (day + 4) % 7 is zero on sundays
  function automatic longint unsigned sunday_on_or_after(input longint unsigned day);
    longint unsigned wd;
    wd = (day + 4) % 7;
    return day + (7 - wd) % 7;
  endfunction

  // second sunday of march and first sunday of november at the shadow hours;
  // hours above 23 just push the boundary into the following monday
  function automatic dst_window_t year_window(input longint unsigned yr);
    dst_window_t     w;
    longint unsigned open_day, close_day;
    open_day       = sunday_on_or_after(day_of_first(yr, 3)) + 7;
    close_day      = sunday_on_or_after(day_of_first(yr, 11));
    w.in_dst       = 1'b0;
    w.window_start = WIN_W'(open_day * SEC_IN_DAY + open_hour * SEC_IN_HOUR);
    w.window_end   = WIN_W'(close_day * SEC_IN_DAY + close_hour * SEC_IN_HOUR);
    return w;
  endfunction

  function automatic dst_window_t predict_dst_window(input logic [TS_W-1:0] ts);
    dst_window_t w;
    w        = year_window(civil_year(ts / SEC_IN_DAY));
    w.in_dst = (ts >= w.window_start) && (ts < w.window_end);
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // a third uniform over all 34 bits, the rest close to a dst boundary or to
  // new year, where the flag and the year lookup can go wrong
  function automatic logic [TS_W-1:0] random_epoch();
    int unsigned     pick;
    longint unsigned yr, base;
    longint          off, ts;
    dst_window_t     w;
    pick = $urandom_range(99);
    if (pick < 35) begin
      return {2'($urandom()), 32'($urandom())};
    end
    if (pick < 75) begin
      yr   = $urandom_range(2513, 1970);
      w    = year_window(yr);
      base = $urandom_range(1) ? w.window_end : w.window_start;
    end else begin
      // january 1 is december 1 of the year before plus 31 days
      yr   = $urandom_range(2514, 1971);
      base = (day_of_first(yr - 1, 12) + 31) * SEC_IN_DAY;
    end
    if ($urandom_range(3) != 0) begin
      off = longint'($urandom_range(6)) - 3;
    end else begin
      off = longint'($urandom_range(2 * PROBE_SPAN)) - PROBE_SPAN;
    end
    ts = longint'(base) + off;
    if (ts < 0 || ts > longint'(TS_MAX)) begin
      return {2'($urandom()), 32'($urandom())};
    end
    return ts[TS_W-1:0];
  endfunction

  task automatic queue_epoch(input logic [TS_W-1:0] ts);
    epochs_to_send.push_back(ts);
    epochs_queued++;
  endtask

  task automatic queue_random(input int n);
    repeat (n) queue_epoch(random_epoch());
  endtask

  // every queued timestamp accepted and every window seen, then let the pipe empty
  task automatic wait_idle();
    while (epochs_accepted != epochs_queued || dst_windows_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (PIPE_DEPTH) @(posedge clk);
  endtask

  task automatic write_hour(input cfg_reg_t which, input logic [HOUR_W-1:0] hour);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= hour;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (which == REG_START_HOUR) begin
      open_hour = hour;
    end else begin
      close_hour = hour;
    end
  endtask

  // only called with the block idle, so the shadow never races an item
  task automatic run_phase(input logic [HOUR_W-1:0] start_hr,
                           input logic [HOUR_W-1:0] end_hr,
                           input int send_pct, input int recv_pct, input int n);
    write_hour(REG_START_HOUR, start_hr);
    write_hour(REG_END_HOUR, end_hr);
    hour_settings++;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    queue_random(n);
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // driver: one timestamp transaction per handshake, valid held until taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        dst_windows_due.push_back(predict_dst_window(epoch_seconds));
        epochs_accepted++;
      end
      // load a new transaction only when the output slot is free
      if (!item_valid || item_ready) begin
        if (epochs_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          item_valid    <= 1'b1;
          epoch_seconds <= epochs_to_send.pop_front();
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here so the monitor only looks at the count
  always @(posedge clk) begin
    if (rst) begin
      rx_hold_left <= 0;
    end else if (rx_hold_req) begin
      rx_hold_left <= RX_HOLD_CYCLES;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compare each result transaction with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (dst_windows_due.size() == 0) begin
          $error("result transaction with no timestamp outstanding");
          fail_count++;
        end else begin
          due_head = dst_windows_due.pop_front();
          if (in_dst !== due_head.in_dst) begin
            $error("in_dst: expected %0d, got %0d", due_head.in_dst, in_dst);
            fail_count++;
          end
          if (window_start !== due_head.window_start) begin
            $error("window_start: expected %0d, got %0d", due_head.window_start,
                   window_start);
            fail_count++;
          end
          if (window_end !== due_head.window_end) begin
            $error("window_end: expected %0d, got %0d", due_head.window_end, window_end);
            fail_count++;
          end
          windows_checked++;
        end
      end
      result_ready <= (rx_hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    dst_window_t w;
    logic [TS_W-1:0] jan_first;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: reset hours, field extremes, alternating bit patterns, both
    // sides of each boundary, leap and non-leap century years, new year
    queue_epoch('0);
    queue_epoch(TS_W'(TS_MAX));
    queue_epoch({17{2'b10}});
    queue_epoch({17{2'b01}});
    w = year_window(2024);
    queue_epoch(TS_W'(w.window_start - 1));
    queue_epoch(TS_W'(w.window_start));
    queue_epoch(TS_W'(w.window_end - 1));
    queue_epoch(TS_W'(w.window_end));
    w = year_window(2000);
    queue_epoch(TS_W'(w.window_start));
    queue_epoch(TS_W'(w.window_end - 1));
    w = year_window(2100);
    queue_epoch(TS_W'(w.window_start - 1));
    queue_epoch(TS_W'(w.window_end));
    // dec 31 23:59:59 and jan 1 00:00:00 both fall outside the window
    jan_first = TS_W'((day_of_first(2023, 12) + 31) * SEC_IN_DAY);
    queue_epoch(jan_first - 1);
    queue_epoch(jan_first);
    w = year_window(1970);
    queue_epoch(TS_W'(w.window_start));
    w = year_window(2513);
    queue_epoch(TS_W'(w.window_end - 1));
    w = year_window(2514);
    queue_epoch(TS_W'(w.window_start));
    wait_idle();

    // hour extremes, including the out-of-range values that spill into monday
    run_phase(5'd0,  5'd0,  0,  0,  120);
    run_phase(5'd23, 5'd23, 73, 0,  120);
    run_phase(5'd31, 5'd31, 0,  73, 120);
    run_phase(5'd0,  5'd31, 12, 12, 120);

    // back-pressure: receiver holds off while the sender keeps offering, so
    // the pipeline fills and item_ready drops
    write_hour(REG_START_HOUR, 5'd31);
    write_hour(REG_END_HOUR, 5'd0);
    hour_settings++;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    queue_random(150);
    @(posedge clk);
    rx_hold_req <= 1'b1;
    @(posedge clk);
    rx_hold_req <= 1'b0;
    wait_idle();

    // random hour pairs over the full 5-bit range
    repeat (3) begin
      run_phase(5'($urandom_range(31)), 5'($urandom_range(31)), 12, 12, 50);
    end

    wait_idle();
    repeat (PIPE_DEPTH * 4) @(posedge clk);

    $display("checked %0d dst windows over %0d hour settings", windows_checked,
             hour_settings);
    $display("covered boundary seconds, new year edges and the full timestamp range");
    if (fail_count == 0) begin
      $display("[us_dst_window_check] OK");
    end else begin
      $display("[us_dst_window_check] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/usdst_pkg.sv
rtl/core/us_dst_window_check.sv
sim/testbench.sv
